/* rtl/tpc_pkg.sv */
package tpc_pkg;

   // Width of the result mask; lanes at index MASK_BITS and above are dropped.
   localparam int MASK_BITS = 8;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLIP_MAX_X = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLIP_MAX_Y = 1'd1;

   // Reset value of both clip limits.
   localparam int CLIP_RESET = 1000;

   // Load strobes for the two per-lane stages.
   typedef struct packed {
      logic load4;
      logic load5;
   } stage_ctl_type;

endpackage

/* rtl/tpc_lane.sv */
module tpc_lane #(
   parameter int COORD_BITS = 12,
   parameter int LANE       = 0
) (
   input  logic                                clock,
   input  tpc_pkg::stage_ctl_type              ctl,
   input  logic signed [2*COORD_BITS+4:0]      ux0,
   input  logic signed [2*COORD_BITS+4:0]      uy0,
   input  logic signed [COORD_BITS:0]          acy,
   input  logic signed [COORD_BITS:0]          aby,
   input  logic        [COORD_BITS-1:0]        px0,
   input  logic        [COORD_BITS-1:0]        clip_max_x,
   input  logic signed [2*COORD_BITS+4:0]      uz,
   input  logic                                gate,
   output logic                                covered
);

   localparam int EW = 2 * COORD_BITS + 5;
   localparam logic signed [EW-1:0] STEP = EW'(LANE);

   logic signed [EW-1:0] acy_e;
   logic signed [EW-1:0] aby_e;
   logic signed [EW-1:0] ux_in;
   logic signed [EW-1:0] uy_in;
   logic        [COORD_BITS:0] px;
   logic                 xok_in;

   logic signed [EW-1:0] ux_ff;
   logic signed [EW-1:0] uy_ff;
   logic                 xok_ff;

   logic signed [EW:0]   ux_w;
   logic signed [EW:0]   uy_w;
   logic signed [EW:0]   uz_w;
   logic signed [EW:0]   sum;
   logic                 weights_ok;
   logic                 covered_ff;

   // Edge values step linearly along the row, so each lane adds its offset.
   assign acy_e  = {{(EW-COORD_BITS-1){acy[COORD_BITS]}}, acy};
   assign aby_e  = {{(EW-COORD_BITS-1){aby[COORD_BITS]}}, aby};
   assign ux_in  = ux0 + acy_e * STEP;
   assign uy_in  = uy0 - aby_e * STEP;
   assign px     = {1'b0, px0} + (COORD_BITS+1)'(LANE);
   assign xok_in = px <= {1'b0, clip_max_x};

   always_ff @(posedge clock) begin
      if (ctl.load4) begin
         ux_ff  <= ux_in;
         uy_ff  <= uy_in;
         xok_ff <= xok_in;
      end
   end

   assign ux_w = {ux_ff[EW-1], ux_ff};
   assign uy_w = {uy_ff[EW-1], uy_ff};
   assign uz_w = {uz[EW-1], uz};
   assign sum  = ux_w + uy_w;

   always_comb begin
      if (!uz[EW-1]) begin
         weights_ok = !ux_ff[EW-1] && !uy_ff[EW-1] && (sum <= uz_w);
      end else begin
         weights_ok = (ux_ff <= 0) && (uy_ff <= 0) && (sum >= uz_w);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load5) begin
         covered_ff <= gate && xok_ff && weights_ok;
      end
   end

   assign covered = covered_ff;

endmodule

/* rtl/triangle_pixel_coverage.sv */
// Channel  Direction  Handshake                 Payload
// req      in         req_tvalid / req_tready   req_tdata: six vertex coordinates, run_x, run_y
// rsp      out        rsp_tvalid / rsp_tready   rsp_tdata: cover_mask, rsp_tuser: degenerate
// csr      in         csr_wen (no back-pressure) csr_index, csr_wdata
//
// One request enters per cycle while nothing stalls; the pipeline is built of
// five register stages (operand setup, multipliers, edge differences,
// per-lane stepping, per-lane weight test).
// Reset is synchronous and active high; it empties the pipeline and loads both
// clip limits with 1000. A stalled response freezes only the stages behind it
// that are full, so empty stages keep taking requests and nothing is lost.
module triangle_pixel_coverage #(
   parameter int LANES      = 8,
   parameter int COORD_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0 up: vert_a_x, vert_a_y, vert_b_x, vert_b_y,
   // vert_c_x, vert_c_y, run_x, run_y, each COORD_BITS wide.
   input  logic [8*COORD_BITS-1:0]             req_tdata,

   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Fields from bit 0 up: cover_mask (8 bits).
   output logic [tpc_pkg::MASK_BITS-1:0]       rsp_tdata,
   // Fields from bit 0 up: degenerate (1 bit).
   output logic [0:0]                          rsp_tuser,

   input  logic                                csr_wen,
   input  logic [tpc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [COORD_BITS-1:0]               csr_wdata
);

   localparam int W  = COORD_BITS;
   localparam int PW = 2 * COORD_BITS + 3;   // width of one product
   localparam int EW = 2 * COORD_BITS + 5;   // width of the edge values
   // Only lanes that reach the mask are built.
   localparam int MASK_LANES = (LANES < tpc_pkg::MASK_BITS) ? LANES : tpc_pkg::MASK_BITS;

   // Clip registers.
   logic [W-1:0] clip_x_ff;
   logic [W-1:0] clip_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_x_ff <= W'(tpc_pkg::CLIP_RESET);
         clip_y_ff <= W'(tpc_pkg::CLIP_RESET);
      end else if (csr_wen) begin
         case (csr_index)
            tpc_pkg::CSR_CLIP_MAX_X: clip_x_ff <= csr_wdata;
            tpc_pkg::CSR_CLIP_MAX_Y: clip_y_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Pipeline control: a stage loads when it is empty or when the stage after
   // it moves on.
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5;
   tpc_pkg::stage_ctl_type lane_ctl;

   assign en5 = !v5_ff || rsp_tready;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign lane_ctl.load4 = en4;
   assign lane_ctl.load5 = en5;
   assign req_tready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_tvalid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   // Stage 1: unpack the request, form the vertex and pixel offsets and test the row clip.
   logic [W-1:0] ax, ay, bx, by, cx, cy, run_x, run_y;
   assign ax    = req_tdata[0*W +: W];
   assign ay    = req_tdata[1*W +: W];
   assign bx    = req_tdata[2*W +: W];
   assign by    = req_tdata[3*W +: W];
   assign cx    = req_tdata[4*W +: W];
   assign cy    = req_tdata[5*W +: W];
   assign run_x = req_tdata[6*W +: W];
   assign run_y = req_tdata[7*W +: W];

   logic signed [W:0]   abx_in, aby_in, acx_in, acy_in;
   logic signed [W+1:0] pay_in, pax_in;
   logic                yok_in;

   assign abx_in = {bx[W-1], bx} - {ax[W-1], ax};
   assign aby_in = {by[W-1], by} - {ay[W-1], ay};
   assign acx_in = {cx[W-1], cx} - {ax[W-1], ax};
   assign acy_in = {cy[W-1], cy} - {ay[W-1], ay};
   // The pixel-to-vertex offset is taken at the leftmost pixel of the run.
   assign pay_in = {{2{ay[W-1]}}, ay} - {2'b00, run_y};
   assign pax_in = {{2{ax[W-1]}}, ax} - {2'b00, run_x};
   assign yok_in = run_y <= clip_y_ff;

   logic signed [W:0]   abx1_ff, aby1_ff, acx1_ff, acy1_ff;
   logic signed [W+1:0] pay1_ff, pax1_ff;
   logic [W-1:0]        px1_ff;
   logic                yok1_ff;

   always_ff @(posedge clock) begin
      if (en1) begin
         abx1_ff <= abx_in;
         aby1_ff <= aby_in;
         acx1_ff <= acx_in;
         acy1_ff <= acy_in;
         pay1_ff <= pay_in;
         pax1_ff <= pax_in;
         px1_ff  <= run_x;
         yok1_ff <= yok_in;
      end
   end

   // Stage 2: the six cross-product terms, one multiplier each.
   logic signed [PW-1:0] abx_e, aby_e, acx_e, acy_e, pay_e, pax_e;
   assign abx_e = {{(PW-W-1){abx1_ff[W]}}, abx1_ff};
   assign aby_e = {{(PW-W-1){aby1_ff[W]}}, aby1_ff};
   assign acx_e = {{(PW-W-1){acx1_ff[W]}}, acx1_ff};
   assign acy_e = {{(PW-W-1){acy1_ff[W]}}, acy1_ff};
   assign pay_e = {{(PW-W-2){pay1_ff[W+1]}}, pay1_ff};
   assign pax_e = {{(PW-W-2){pax1_ff[W+1]}}, pax1_ff};

   logic signed [PW-1:0] p_abx_acy_ff, p_acx_aby_ff, p_acx_pay_ff;
   logic signed [PW-1:0] p_pax_acy_ff, p_pax_aby_ff, p_abx_pay_ff;
   logic signed [W:0]    acy2_ff, aby2_ff;
   logic [W-1:0]         px2_ff;
   logic                 yok2_ff;

   always_ff @(posedge clock) begin
      if (en2) begin
         p_abx_acy_ff <= abx_e * acy_e;
         p_acx_aby_ff <= acx_e * aby_e;
         p_acx_pay_ff <= acx_e * pay_e;
         p_pax_acy_ff <= pax_e * acy_e;
         p_pax_aby_ff <= pax_e * aby_e;
         p_abx_pay_ff <= abx_e * pay_e;
         acy2_ff      <= acy1_ff;
         aby2_ff      <= aby1_ff;
         px2_ff       <= px1_ff;
         yok2_ff      <= yok1_ff;
      end
   end

   // Stage 3: twice the signed area and the edge values at the first pixel.
   logic signed [PW-1:0] uz_d, ux_d, uy_d;
   assign uz_d = p_abx_acy_ff - p_acx_aby_ff;
   assign ux_d = p_acx_pay_ff - p_pax_acy_ff;
   assign uy_d = p_pax_aby_ff - p_abx_pay_ff;

   logic signed [EW-1:0] uz3_ff, ux3_ff, uy3_ff;
   logic signed [W:0]    acy3_ff, aby3_ff;
   logic [W-1:0]         px3_ff;
   logic                 yok3_ff;

   always_ff @(posedge clock) begin
      if (en3) begin
         uz3_ff  <= {{(EW-PW){uz_d[PW-1]}}, uz_d};
         ux3_ff  <= {{(EW-PW){ux_d[PW-1]}}, ux_d};
         uy3_ff  <= {{(EW-PW){uy_d[PW-1]}}, uy_d};
         acy3_ff <= acy2_ff;
         aby3_ff <= aby2_ff;
         px3_ff  <= px2_ff;
         yok3_ff <= yok2_ff;
      end
   end

   // Stage 4: lanes step their edge values; the shared part keeps the area,
   // the degenerate flag and the row gate.
   logic signed [EW-1:0] uz4_ff;
   logic                 gate4_ff;
   logic                 deg4_ff;

   always_ff @(posedge clock) begin
      if (en4) begin
         uz4_ff   <= uz3_ff;
         gate4_ff <= (uz3_ff != '0) && yok3_ff;
         deg4_ff  <= uz3_ff == '0;
      end
   end

   // Stage 5: each lane tests its weights; the result register holds here.
   logic deg5_ff;

   always_ff @(posedge clock) begin
      if (en5) begin
         deg5_ff <= deg4_ff;
      end
   end

   logic [tpc_pkg::MASK_BITS-1:0] mask;

   for (genvar k = 0; k < tpc_pkg::MASK_BITS; k++) begin : g_lane
      if (k < MASK_LANES) begin : g_on
         tpc_lane #(
            .COORD_BITS (COORD_BITS),
            .LANE       (k)
         ) u_lane (
            .clock      (clock),
            .ctl        (lane_ctl),
            .ux0        (ux3_ff),
            .uy0        (uy3_ff),
            .acy        (acy3_ff),
            .aby        (aby3_ff),
            .px0        (px3_ff),
            .clip_max_x (clip_x_ff),
            .uz         (uz4_ff),
            .gate       (gate4_ff),
            .covered    (mask[k])
         );
      end else begin : g_off
         assign mask[k] = 1'b0;
      end
   end

   assign rsp_tvalid   = v5_ff;
   assign rsp_tdata    = mask;
   assign rsp_tuser[0] = deg5_ff;

`ifndef NO_ASSERTIONS
   // A degenerate triangle never covers a pixel.
   a_deg_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("degenerate response with a non-empty mask");

   // Mask bits of lanes that are not built stay clear.
   a_unused_lanes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata >> MASK_LANES) == '0)
      else $error("mask bit set beyond the built lanes");

   // The input is held off only while the first stage is full.
   a_ready_bubble: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> v1_ff)
      else $error("request refused with an empty first stage");

   // A full stage whose successor is frozen keeps its request.
   a_stage4_hold: assert property (@(posedge clock) disable iff (reset)
      v4_ff && !en5 |=> v4_ff)
      else $error("stage four dropped a stalled request");
`endif

endmodule

/* test/tb_triangle_pixel_coverage.sv */
module tb_triangle_pixel_coverage;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LANES      = 8;
   localparam int COORD_BITS = 12;

   // One request as it travels on req_tdata. A packed struct lists its first
   // member in the top bits, so the members stand here in reverse order and
   // vert_a_x lands in bits 11:0.
   typedef struct packed {
      logic        [COORD_BITS-1:0] run_y;
      logic        [COORD_BITS-1:0] run_x;
      logic signed [COORD_BITS-1:0] vert_c_y;
      logic signed [COORD_BITS-1:0] vert_c_x;
      logic signed [COORD_BITS-1:0] vert_b_y;
      logic signed [COORD_BITS-1:0] vert_b_x;
      logic signed [COORD_BITS-1:0] vert_a_y;
      logic signed [COORD_BITS-1:0] vert_a_x;
   } pixel_run_req_type;

   // The coverage answer for one run of pixels.
   typedef struct packed {
      logic [tpc_pkg::MASK_BITS-1:0] cover_mask;
      logic                          degenerate;
   } coverage_rsp_type;

   // All block inputs start at known values; reset is held from time zero.
   logic                               clock      = 1'b0;
   logic                               reset      = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [8*COORD_BITS-1:0]            req_tdata  = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [tpc_pkg::MASK_BITS-1:0]      rsp_tdata;
   logic [0:0]                         rsp_tuser;
   logic                               csr_wen    = 1'b0;
   logic [tpc_pkg::CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [COORD_BITS-1:0]              csr_wdata  = '0;

   // Our own copy of the two clip limits, updated whenever we write one.
   logic [COORD_BITS-1:0] clip_x_limit = COORD_BITS'(tpc_pkg::CLIP_RESET);
   logic [COORD_BITS-1:0] clip_y_limit = COORD_BITS'(tpc_pkg::CLIP_RESET);

   // Predicted answers, oldest first, one per accepted request.
   coverage_rsp_type expected_coverage[$];

   // Idle switches for each side of the block.
   bit req_idle_on = 1'b0;
   bit rsp_idle_on = 1'b0;

   int mismatch_count   = 0;
   int request_count    = 0;
   int covered_pixels   = 0;
   int degenerate_count = 0;
   int clip_settings    = 1;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   triangle_pixel_coverage #(
      .LANES      (LANES),
      .COORD_BITS (COORD_BITS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Coverage predictor. The triangle is tested with the exact integer cross
   // product: uz is twice the signed area, and ux and uy are the unnormalized
   // barycentric weights of the second and third vertex. Instead of dividing,
   // the weights are compared against zero and against uz, with the direction
   // of every comparison flipped for a clockwise triangle. A zero area covers
   // nothing and raises the degenerate flag. Lanes past either clip limit are
   // never covered; pixel x is formed without wrap, so lanes that run past
   // the largest coordinate simply fall outside the limit.
   function automatic coverage_rsp_type predict_coverage(pixel_run_req_type r);
      longint ax, ay, abx, aby, acx, acy, uz;
      longint px, py, pay, pax, ux, uy, wsum;
      logic in_tri;
      coverage_rsp_type res;
      ax  = r.vert_a_x;
      ay  = r.vert_a_y;
      abx = longint'(r.vert_b_x) - ax;
      aby = longint'(r.vert_b_y) - ay;
      acx = longint'(r.vert_c_x) - ax;
      acy = longint'(r.vert_c_y) - ay;
      uz  = abx * acy - acx * aby;
      py  = longint'(r.run_y);
      res.cover_mask = '0;
      res.degenerate = (uz == 0);
      if (uz != 0 && py <= longint'(clip_y_limit)) begin
         pay = ay - py;
         for (int k = 0; k < LANES; k++) begin
            px = longint'(r.run_x) + k;
            if (px > longint'(clip_x_limit))
               continue;
            pax  = ax - px;
            ux   = acx * pay - pax * acy;
            uy   = pax * aby - abx * pay;
            wsum = ux + uy;
            if (uz > 0)
               in_tri = (ux >= 0) && (uy >= 0) && (wsum <= uz);
            else
               in_tri = (ux <= 0) && (uy <= 0) && (wsum >= uz);
            // Lanes beyond the mask width would be dropped; with eight lanes
            // every lane has its own bit.
            if (in_tri && k < tpc_pkg::MASK_BITS)
               res.cover_mask[k] = 1'b1;
         end
      end
      return res;
   endfunction

   function automatic logic signed [COORD_BITS-1:0] sat_coord(int v);
      if (v < -2048)
         return -12'sd2048;
      if (v > 2047)
         return 12'sd2047;
      return COORD_BITS'(v);
   endfunction

   function automatic logic [COORD_BITS-1:0] sat_pixel(int v);
      if (v < 0)
         return '0;
      if (v > 4095)
         return '1;
      return COORD_BITS'(v);
   endfunction

   // A random offset in -span..span.
   function automatic int jitter(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic pixel_run_req_type tri_req(int ax, int ay, int bx, int by,
                                                 int cx, int cy, int rx, int ry);
      pixel_run_req_type r;
      r.vert_a_x = sat_coord(ax);
      r.vert_a_y = sat_coord(ay);
      r.vert_b_x = sat_coord(bx);
      r.vert_b_y = sat_coord(by);
      r.vert_c_x = sat_coord(cx);
      r.vert_c_y = sat_coord(cy);
      r.run_x    = sat_pixel(rx);
      r.run_y    = sat_pixel(ry);
      return r;
   endfunction

   // Random requests. Most are small triangles with the pixel run placed
   // close to them, so that runs cross edges and vertices and reach partial
   // masks; half of those sit around the clip corner. The rest are collinear
   // triangles, triangles across the whole coordinate range, and raw noise.
   function automatic pixel_run_req_type make_random_request();
      int pick, ox, oy, span, dx, dy, m1, m2;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 1) == 1) begin
         ox = int'(clip_x_limit) + jitter(30);
         oy = int'(clip_y_limit) + jitter(30);
      end else begin
         ox = $urandom_range(0, 1100);
         oy = $urandom_range(0, 1100);
      end
      span = ($urandom_range(0, 2) == 0) ? 40 : 6;
      if (pick < 60) begin
         return tri_req(ox + jitter(span), oy + jitter(span),
                        ox + jitter(span), oy + jitter(span),
                        ox + jitter(span), oy + jitter(span),
                        ox + jitter(span) - 4, oy + jitter(span));
      end else if (pick < 75) begin
         // Collinear vertices, repeated vertices among them.
         dx = jitter(20);
         dy = jitter(20);
         m1 = jitter(2);
         m2 = jitter(2);
         return tri_req(ox, oy, ox + m1 * dx, oy + m1 * dy,
                        ox + m2 * dx, oy + m2 * dy, ox + jitter(8) - 4, oy + jitter(8));
      end else if (pick < 90) begin
         return tri_req(jitter(2048), jitter(2048), jitter(2048), jitter(2048),
                        jitter(2048), jitter(2048), $urandom_range(0, 1200),
                        $urandom_range(0, 1200));
      end
      return pixel_run_req_type'({$urandom, $urandom, $urandom});
   endfunction

   function automatic logic [COORD_BITS-1:0] pick_clip();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         2: return COORD_BITS'($urandom_range(900, 1100));
         default: return COORD_BITS'($urandom_range(0, 4095));
      endcase
   endfunction

   // Offers one request, after an optional idle burst, and waits for it to
   // be taken. The prediction is queued at the edge that accepts it. When no
   // idle burst comes, tvalid simply stays high into the next request.
   task automatic send_request(input pixel_run_req_type item);
      coverage_rsp_type pred;
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= item;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      pred = predict_coverage(item);
      expected_coverage.push_back(pred);
      request_count++;
      covered_pixels += $countones(pred.cover_mask);
      if (pred.degenerate)
         degenerate_count++;
   endtask

   // Stops offering requests and waits for every outstanding answer, then
   // idles on, so the block is quiet.
   task automatic settle_pipeline();
      req_tvalid <= 1'b0;
      while (expected_coverage.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Writes one clip register. The enable is dropped for a cycle afterwards
   // so that two writes in a row never drive it twice in one time step.
   task automatic write_clip(input logic [tpc_pkg::CSR_INDEX_BITS-1:0] index,
                             input logic [COORD_BITS-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (index)
         tpc_pkg::CSR_CLIP_MAX_X: clip_x_limit = value;
         tpc_pkg::CSR_CLIP_MAX_Y: clip_y_limit = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_clips(input logic [COORD_BITS-1:0] max_x,
                            input logic [COORD_BITS-1:0] max_y);
      settle_pipeline();
      write_clip(tpc_pkg::CSR_CLIP_MAX_X, max_x);
      write_clip(tpc_pkg::CSR_CLIP_MAX_Y, max_y);
      clip_settings++;
   endtask

   task automatic note_mismatch(input string what, input int unsigned exp_v,
                                input int unsigned act_v);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("Mismatch in %s at %0t: expected %0h, got %0h",
                  what, $realtime, exp_v, act_v);
   endtask

   // Hand-picked shapes under the reset clip limits of 1000: both windings,
   // pixels exactly on an edge and on a vertex, collinear and repeated
   // vertices, the extreme vertex coordinates, runs that cross the clip
   // limit, and runs at the largest pixel coordinate.
   task automatic test_directed_shapes();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      send_request(tri_req(0, 0, 20, 0, 0, 20, 0, 5));
      send_request(tri_req(0, 0, 0, 20, 20, 0, 0, 5));
      send_request(tri_req(0, 0, 8, 0, 0, 8, 0, 0));
      send_request(tri_req(0, 0, 8, 0, 0, 8, 0, 4));
      send_request(tri_req(0, 0, 8, 0, 0, 8, 0, 8));
      send_request(tri_req(0, 0, 0, 8, 8, 0, 2, 6));
      send_request(tri_req(10, 10, 30, 10, 10, 30, 10, 10));
      send_request(tri_req(10, 10, 30, 10, 10, 30, 3, 10));
      send_request(tri_req(0, 0, 5, 5, 10, 10, 0, 0));
      send_request(tri_req(7, 7, 7, 7, 7, 7, 4, 7));
      send_request(tri_req(3, 9, 3, 9, 20, 1, 0, 5));
      send_request(tri_req(-2048, -2048, 2047, -2048, -2048, 2047, 0, 0));
      send_request(tri_req(-2048, -2048, -2048, 2047, 2047, -2048, 996, 1000));
      send_request(tri_req(-2048, -2048, 2047, -2048, -2048, 2047, 0, 1001));
      send_request(tri_req(-2048, -2048, 2047, 2047, -2048, 2047, 4088, 0));
      send_request(tri_req(-2048, 2047, 2047, 2047, 2047, -2048, 4095, 4095));
      send_request(tri_req(-100, -100, -50, -100, -100, -50, 0, 0));
      send_request(tri_req(0, 0, 100, 1, 0, 1, 0, 0));
      send_request(tri_req(0, 0, 100, 1, 0, 1, 0, 1));
      send_request(tri_req(990, 990, 1010, 990, 990, 1010, 995, 999));
   endtask

   // Both limits at their extremes and mixed, then back at 1000. With both at
   // zero only the origin pixel can be covered; at 4095 lanes past the last column drop.
   task automatic test_clip_extremes();
      logic [COORD_BITS-1:0] corner_x[5] = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd1000};
      logic [COORD_BITS-1:0] corner_y[5] = '{12'd0, 12'd4095, 12'd4095, 12'd0, 12'd1000};
      for (int i = 0; i < 5; i++) begin
         set_clips(corner_x[i], corner_y[i]);
         send_request(tri_req(0, 0, 8, 0, 0, 8, 0, 0));
         send_request(tri_req(-2048, -2048, 2047, 2047, -2048, 2047, 4090, 4095));
         for (int n = 0; n < 30; n++)
            send_request(make_random_request());
      end
   endtask

   // The bulk of the run: five stretches, each but the first under a new pair
   // of clip limits, with idling on both sides, on one side only, and none at
   // all in the last stretch.
   task automatic test_random_triangles();
      bit req_modes[5] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
      bit rsp_modes[5] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
      for (int chunk = 0; chunk < 5; chunk++) begin
         if (chunk > 0)
            set_clips(pick_clip(), pick_clip());
         req_idle_on = req_modes[chunk];
         rsp_idle_on = rsp_modes[chunk];
         for (int n = 0; n < 260; n++)
            send_request(make_random_request());
      end
   endtask

   // The receiving side now and then holds tready low while idling is
   // enabled, and keeps it high otherwise.
   initial begin
      @(posedge clock);
      forever begin
         if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   // Every accepted response is matched against the oldest prediction, one
   // field at a time. Values are read at the edge, before anything driven at
   // that edge takes effect.
   always @(posedge clock) begin
      coverage_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_coverage.size() == 0) begin
            note_mismatch("response with no request outstanding", 0, rsp_tdata);
         end else begin
            want = expected_coverage.pop_front();
            if (rsp_tdata !== want.cover_mask)
               note_mismatch("cover_mask", want.cover_mask, rsp_tdata);
            if (rsp_tuser[0] !== want.degenerate)
               note_mismatch("degenerate", want.degenerate, rsp_tuser[0]);
         end
      end
   end

   // Reset is held from the start and released once; then the tests run in
   // turn and the run ends once every prediction has been matched.
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_shapes();
      test_clip_extremes();
      test_random_triangles();
      settle_pipeline();
      $display("Checked %0d pixel runs under %0d clip settings.",
               request_count, clip_settings);
      $display("%0d pixels were covered and %0d triangles were degenerate.",
               covered_pixels, degenerate_count);
      if (mismatch_count == 0) begin
         $display("triangle_pixel_coverage: match");
      end else begin
         $display("%0d mismatches in total.", mismatch_count);
         $display("triangle_pixel_coverage: mismatch");
      end
      $finish;
   end

   // A correct run needs well under a tenth of this time, even with every
   // request meeting the longest gap and the longest stall.
   initial begin
      #2000000;
      $display("Timed out with %0d responses outstanding.", expected_coverage.size());
      $display("triangle_pixel_coverage: mismatch");
      $finish;
   end

endmodule
